/* sv/casvis_pkg.sv */
// Types, stage map and constants shared by the Casson viscosity pipeline.
package casvis_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  localparam logic [2:0] REG_REGULARIZED = 3'd0;
  localparam logic [2:0] REG_YIELD       = 3'd1;
  localparam logic [2:0] REG_INF_VISC    = 3'd2;
  localparam logic [2:0] REG_MIN_VISC    = 3'd3;
  localparam logic [2:0] REG_MAX_VISC    = 3'd4;
  localparam logic [2:0] REG_GROWTH      = 3'd5;

  localparam int EXP_TERMS  = 13;
  localparam int EXP_CUTOFF = 23;
  localparam int RCP_SH     = 35;

  localparam int DIV_FIRST = 1;
  localparam int DIV_LAST  = 64;
  localparam int SQ_FIRST  = 65;
  localparam int SQ_LAST   = 96;
  localparam int EXP_STG   = 97;
  localparam int TERM_FIRST = 98;
  localparam int TERM_LAST = 133;
  localparam int TSUM_STG  = 134;
  localparam int POW_FIRST = 135;
  localparam int POW_LAST  = 156;
  localparam int D_STG     = 157;
  localparam int AD_STG    = 158;
  localparam int SUM_STG   = 159;
  localparam int SQR_STG   = 160;
  localparam int OUT_STG   = 161;

  localparam logic [34:0] RECIP [2:13] = '{
    35'((64'd1 << RCP_SH) / 64'd2),  35'((64'd1 << RCP_SH) / 64'd3),
    35'((64'd1 << RCP_SH) / 64'd4),  35'((64'd1 << RCP_SH) / 64'd5),
    35'((64'd1 << RCP_SH) / 64'd6),  35'((64'd1 << RCP_SH) / 64'd7),
    35'((64'd1 << RCP_SH) / 64'd8),  35'((64'd1 << RCP_SH) / 64'd9),
    35'((64'd1 << RCP_SH) / 64'd10), 35'((64'd1 << RCP_SH) / 64'd11),
    35'((64'd1 << RCP_SH) / 64'd12), 35'((64'd1 << RCP_SH) / 64'd13)
  };

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] q;
  } div_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] g;
    logic [63:0] mg;
    div_t        dv;
    sqrt_t       a;
    sqrt_t       b;
    sqrt_t       s;
    logic [15:0] n;
    logic [31:0] r32;
    logic [31:0] term;
    logic [63:0] prod;
    logic [66:0] rcp;
    logic [33:0] pos;
    logic [33:0] neg;
    logic [32:0] e;
    logic [16:0] d;
    logic [48:0] ad;
    logic [32:0] sum;
    logic [65:0] sq;
    logic [31:0] eta;
  } pipe_t;

  function automatic div_t div_step(input div_t v, input logic din, input logic [31:0] dv);
    div_t        o;
    logic [32:0] rn;
    logic [32:0] df;
    rn = {v.rem, din};
    df = rn - {1'b0, dv};
    if (rn >= {1'b0, dv}) begin
      o.rem = df[31:0];
      o.q   = {v.q[62:0], 1'b1};
    end else begin
      o.rem = rn[31:0];
      o.q   = {v.q[62:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t v);
    sqrt_t       o;
    logic [35:0] rn;
    logic [35:0] tr;
    rn = {v.rem[33:0], v.x[63:62]};
    tr = {2'b00, v.root, 2'b01};
    o.x = {v.x[61:0], 2'b00};
    if (rn >= tr) begin
      o.rem  = rn - tr;
      o.root = {v.root[30:0], 1'b1};
    end else begin
      o.rem  = rn;
      o.root = {v.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [32:0] exp_neg_frac(input logic [31:0] r);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'h1_0000_0000;
    pos  = term;
    neg  = '0;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = ((term * {32'b0, r}) >> 32) / 64'(k);
      if ((k & 1) != 0) neg = neg + term;
      else pos = pos + term;
    end
    return 33'(pos - neg);
  endfunction

  localparam logic [32:0] EXP_HALF = exp_neg_frac(32'h8000_0000);
  localparam logic [31:0] EXP_ONE  = 32'((64'(EXP_HALF) * 64'(EXP_HALF)) >> 32);

endpackage

/* sv/casson_viscosity_unit.sv */
// Casson apparent viscosity pipeline with optional exponential regularization.
// Usage:
//   Input channel in_valid/in_ready carries one Q16.16 shear rate per transfer.
//   Result channel out_valid/out_ready carries one Q16.16 viscosity per transfer.
//   Configuration channel cfg_valid/cfg_ready writes register cfg_index with
//   cfg_data; cfg_ready is always high. Write only while the pipeline is empty.
// Throughput: one item per cycle unless a waiting result is stalled. The depth is set
//   by the one-bit-per-stage divider (64 stages), the three square roots (32 stages),
//   the exp series (3 stages per term) and the power chain of exp(-1) (22 stages).
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is dropped or repeated.
module casson_viscosity_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [casvis_pkg::DW-1:0] in_shear_rate,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [casvis_pkg::DW-1:0] out_viscosity,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [casvis_pkg::DW-1:0] cfg_data
);
  import casvis_pkg::*;

  logic        regularized_r;
  logic [31:0] yield_stress_r;
  logic [31:0] inf_visc_r;
  logic [31:0] min_visc_r;
  logic [31:0] max_visc_r;
  logic [31:0] growth_r;

  logic [OUT_STG:0] vld_r;
  pipe_t            pipe_r [0:OUT_STG];
  logic             adv;
  logic [63:0]      dividend;
  pipe_t            stg0_nxt;

  assign cfg_ready = 1'b1;
  assign adv       = !vld_r[OUT_STG] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[OUT_STG];
  assign out_viscosity = pipe_r[OUT_STG].eta;
  assign dividend  = {yield_stress_r, 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regularized_r  <= 1'b1;
      yield_stress_r <= 32'h0001_0000;
      inf_visc_r     <= 32'h0001_0000;
      min_visc_r     <= '0;
      max_visc_r     <= '1;
      growth_r       <= 32'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REGULARIZED: regularized_r  <= cfg_data[0];
        REG_YIELD:       yield_stress_r <= cfg_data;
        REG_INF_VISC:    inf_visc_r     <= cfg_data;
        REG_MIN_VISC:    min_visc_r     <= cfg_data;
        REG_MAX_VISC:    max_visc_r     <= cfg_data;
        REG_GROWTH:      growth_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[OUT_STG-1:0], in_valid};
    end
  end

  always_comb begin
    stg0_nxt   = '0;
    stg0_nxt.g = (in_shear_rate == '0) ? 32'd1 : in_shear_rate;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= stg0_nxt;
    end
  end

  for (genvar k = 1; k <= OUT_STG; k++) begin : g_stg
    pipe_t stg_nxt;

    if (k <= DIV_LAST) begin : g_div
      localparam int DJ = k - DIV_FIRST;
      always_comb begin
        stg_nxt = pipe_r[k-1];
        if (k == DIV_FIRST) begin
          stg_nxt.mg = 64'(pipe_r[k-1].g) * 64'(growth_r);
          stg_nxt.dv = div_step('0, dividend[63-DJ], pipe_r[k-1].g);
        end else begin
          stg_nxt.dv = div_step(pipe_r[k-1].dv, dividend[63-DJ], pipe_r[k-1].g);
        end
      end
    end else if (k <= SQ_LAST) begin : g_sqrt
      always_comb begin
        sqrt_t ai;
        sqrt_t bi;
        sqrt_t si;
        stg_nxt = pipe_r[k-1];
        if (k == SQ_FIRST) begin
          ai = '{rem: '0, root: '0, x: pipe_r[k-1].dv.q};
          bi = '{rem: '0, root: '0, x: {16'b0, inf_visc_r, 16'b0}};
          si = '{rem: '0, root: '0, x: pipe_r[k-1].mg};
        end else begin
          ai = pipe_r[k-1].a;
          bi = pipe_r[k-1].b;
          si = pipe_r[k-1].s;
        end
        stg_nxt.a = sqrt_step(ai);
        stg_nxt.b = sqrt_step(bi);
        stg_nxt.s = sqrt_step(si);
      end
    end else if (k == EXP_STG) begin : g_exp
      always_comb begin
        stg_nxt      = pipe_r[k-1];
        stg_nxt.n    = pipe_r[k-1].s.root[31:16];
        stg_nxt.r32  = {pipe_r[k-1].s.root[15:0], 16'b0};
        stg_nxt.term = {pipe_r[k-1].s.root[15:0], 16'b0};
        stg_nxt.pos  = 34'h1_0000_0000;
        stg_nxt.neg  = {2'b00, pipe_r[k-1].s.root[15:0], 16'b0};
      end
    end else if (k <= TERM_LAST) begin : g_term
      localparam int TK = (k - TERM_FIRST) / 3 + 2;
      localparam int PH = (k - TERM_FIRST) % 3;
      if (PH == 0) begin : g_mul
        always_comb begin
          stg_nxt      = pipe_r[k-1];
          stg_nxt.prod = 64'(pipe_r[k-1].term) * 64'(pipe_r[k-1].r32);
        end
      end else if (PH == 1) begin : g_rcp
        always_comb begin
          stg_nxt     = pipe_r[k-1];
          stg_nxt.rcp = 67'(pipe_r[k-1].prod[63:32]) * 67'(RECIP[TK]);
        end
      end else begin : g_fix
        always_comb begin
          logic [31:0] q0;
          logic [31:0] rm;
          logic [31:0] qt;
          stg_nxt = pipe_r[k-1];
          q0 = pipe_r[k-1].rcp[66:RCP_SH];
          rm = pipe_r[k-1].prod[63:32] - 32'(q0 * 32'(TK));
          qt = (rm >= 32'(TK)) ? q0 + 32'd1 : q0;
          stg_nxt.term = qt;
          if ((TK & 1) != 0) stg_nxt.neg = pipe_r[k-1].neg + 34'(qt);
          else stg_nxt.pos = pipe_r[k-1].pos + 34'(qt);
        end
      end
    end else if (k == TSUM_STG) begin : g_tsum
      always_comb begin
        stg_nxt   = pipe_r[k-1];
        stg_nxt.e = 33'(pipe_r[k-1].pos - pipe_r[k-1].neg);
      end
    end else if (k <= POW_LAST) begin : g_pow
      localparam int PI = k - POW_FIRST;
      always_comb begin
        logic [64:0] pm;
        stg_nxt = pipe_r[k-1];
        pm = 65'(pipe_r[k-1].e) * 65'(EXP_ONE);
        if (16'(PI) < pipe_r[k-1].n) stg_nxt.e = pm[64:32];
      end
    end else if (k == D_STG) begin : g_d
      always_comb begin
        logic [32:0] ev;
        logic [33:0] om;
        stg_nxt = pipe_r[k-1];
        ev = (pipe_r[k-1].n >= 16'(EXP_CUTOFF)) ? 33'd0 : pipe_r[k-1].e;
        om = 34'h1_0000_0000 - 34'(ev);
        stg_nxt.d = om[32:16];
      end
    end else if (k == AD_STG) begin : g_ad
      always_comb begin
        stg_nxt    = pipe_r[k-1];
        stg_nxt.ad = 49'(pipe_r[k-1].a.root) * 49'(pipe_r[k-1].d);
      end
    end else if (k == SUM_STG) begin : g_sum
      always_comb begin
        logic [31:0] cv;
        stg_nxt = pipe_r[k-1];
        cv = regularized_r ? pipe_r[k-1].ad[47:16] : pipe_r[k-1].a.root;
        stg_nxt.sum = {1'b0, cv} + {1'b0, pipe_r[k-1].b.root};
      end
    end else if (k == SQR_STG) begin : g_sqr
      always_comb begin
        stg_nxt    = pipe_r[k-1];
        stg_nxt.sq = 66'(pipe_r[k-1].sum) * 66'(pipe_r[k-1].sum);
      end
    end else begin : g_out
      always_comb begin
        logic [31:0] ev;
        stg_nxt = pipe_r[k-1];
        ev = (|pipe_r[k-1].sq[65:48]) ? '1 : pipe_r[k-1].sq[47:16];
        if (!regularized_r) begin
          if (ev > max_visc_r) ev = max_visc_r;
          if (ev < min_visc_r) ev = min_visc_r;
        end
        stg_nxt.eta = ev;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[k] <= stg_nxt;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("input transfer not captured");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the Casson viscosity pipeline.
`timescale 1ns / 100ps

module testbench;
  import casvis_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int PIPE_DEPTH = 161;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_shear_rate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_viscosity;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic        cur_regularized;
  logic [31:0] cur_yield;
  logic [31:0] cur_inf_visc;
  logic [31:0] cur_min_visc;
  logic [31:0] cur_max_visc;
  logic [31:0] cur_growth;

  logic [31:0] viscosity_q[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  casson_viscosity_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] series_exp_neg(input logic [63:0] r);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'h1_0000_0000;
    pos  = term;
    neg  = '0;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * r) >> 32) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] one_minus_decay(input logic [63:0] s);
    logic [63:0] n;
    logic [63:0] h;
    logic [63:0] e1;
    logic [63:0] e;
    n = s >> 16;
    e = '0;
    if (n < 23) begin
      h  = series_exp_neg(64'h8000_0000);
      e1 = (h * h) >> 32;
      e  = series_exp_neg((s & 64'hffff) << 16);
      for (int i = 0; i < n; i++) e = (e * e1) >> 32;
    end
    return (64'h1_0000_0000 - e) >> 16;
  endfunction

  function automatic logic [31:0] casson_viscosity(input logic [31:0] rate);
    logic [63:0]  g;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  c;
    logic [63:0]  sum;
    logic [127:0] sq;
    logic [31:0]  eta;
    g = (rate == 0) ? 64'd1 : 64'(rate);
    a = isqrt((128'(cur_yield) << 32) / 128'(g));
    b = isqrt(128'(cur_inf_visc) << 16);
    if (cur_regularized) c = (a * one_minus_decay(isqrt(128'(cur_growth) * 128'(g)))) >> 16;
    else c = a;
    sum = c + b;
    sq  = (128'(sum) * 128'(sum)) >> 16;
    eta = (sq > 128'hffff_ffff) ? 32'hffff_ffff : sq[31:0];
    if (!cur_regularized) begin
      if (eta > cur_max_visc) eta = cur_max_visc;
      if (eta < cur_min_visc) eta = cur_min_visc;
    end
    return eta;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (viscosity_q.size() == 0) begin
        $error("viscosity: expected none, actual %h", out_viscosity);
        fail_count++;
      end else begin
        if (out_viscosity !== viscosity_q[0]) begin
          $error("viscosity: expected %h, actual %h", viscosity_q[0], out_viscosity);
          fail_count++;
        end
        void'(viscosity_q.pop_front());
      end
    end
  end

  task automatic send_rate(input logic [31:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_shear_rate <= rate;
    do @(posedge clk); while (!in_ready);
    viscosity_q.push_back(casson_viscosity(rate));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (viscosity_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_REGULARIZED: cur_regularized = data[0];
      REG_YIELD:       cur_yield = data;
      REG_INF_VISC:    cur_inf_visc = data;
      REG_MIN_VISC:    cur_min_visc = data;
      REG_MAX_VISC:    cur_max_visc = data;
      REG_GROWTH:      cur_growth = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic r, input logic [31:0] y, input logic [31:0] inf,
                            input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] m);
    drain();
    write_reg(REG_REGULARIZED, {31'b0, r});
    write_reg(REG_YIELD, y);
    write_reg(REG_INF_VISC, inf);
    write_reg(REG_MIN_VISC, lo);
    write_reg(REG_MAX_VISC, hi);
    write_reg(REG_GROWTH, m);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(7))
      0: return 32'($urandom_range(3));
      1: return $urandom_range(1) ? 32'hffff_ffff : 32'hffff_fffe;
      2: return 32'($urandom_range(32'h0003_ffff));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
      1: return 32'($urandom_range(32'h0010_0000));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_rate(32'h0000_0000);
    send_rate(32'h0000_0001);
    send_rate(32'h0001_0000);
    send_rate(32'hffff_ffff);
    send_rate(32'h0211_0000);
    send_rate(32'h020f_ffff);
    drain();
    write_reg(REG_UNUSED, 32'hdead_beef);
    cfg_valid <= 1'b0;
    send_rate(32'h0001_0000);
  endtask

  task automatic test_regularized_extremes;
    set_config(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    send_rate(32'h0000_0000);
    send_rate(32'hffff_ffff);
    set_config(1'b1, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_rate(32'h0000_0001);
    send_rate(32'h8000_0000);
    set_config(1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_rate(32'h0211_0000);
    send_rate(32'h0210_ffff);
  endtask

  task automatic test_clip_extremes;
    set_config(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0);
    send_rate(32'h0000_0000);
    send_rate(32'hffff_ffff);
    set_config(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0008_0000, 32'h0);
    send_rate(32'h0000_0001);
    send_rate(32'h0001_0000);
    send_rate(32'hffff_ffff);
    set_config(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0009_0000, 32'h0003_0000, 32'h0);
    send_rate(32'h0001_0000);
    send_rate(32'h0000_0010);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int p = 0; p < 2; p++) begin
      set_config(p == 0, rand_value(), rand_value(), rand_value(), rand_value(),
                 rand_value());
      for (int i = 0; i < count; i++) send_rate(rand_rate());
    end
  endtask

  initial begin
    cur_regularized = 1'b1;
    cur_yield       = 32'h0001_0000;
    cur_inf_visc    = 32'h0001_0000;
    cur_min_visc    = 32'h0;
    cur_max_visc    = 32'hffff_ffff;
    cur_growth      = 32'h0001_0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_regularized_extremes();
    test_clip_extremes();
    test_random_phase(0, 0, 135);
    test_random_phase(54, 0, 135);
    test_random_phase(0, 54, 135);
    test_random_phase(15, 15, 135);
    test_random_phase(0, 0, 135);
    drain();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (fail_count == 0 && viscosity_q.size() == 0) begin
      $display("casson_viscosity_unit verification clean");
    end else begin
      $display("casson_viscosity_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("casson_viscosity_unit verification failed");
    $finish;
  end

endmodule
